### rtl/core/ebct_pkg.sv
// ebct_pkg: shared types, register indexes and constants for the ema baseline tracker
// no dependencies
`timescale 1ns / 1ps
package ebct_pkg;
  localparam int unsigned ONE_Q16 = 65536;
  localparam int unsigned ONE_Q15 = 32768;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_EPS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_W_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W_HUM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_W_FLAT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_W_CLAR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FREEZE = 3'd7;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EMA  = 7'b0000010,
    ST_DLD  = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_SUM  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;
endpackage

### rtl/core/ema_baseline_confidence_tracker_top.sv
// ema baseline tracker: one shared 25x17 multiplier and one restoring divider
// per window: 5 ema updates x 2 products (skipped when seeding or frozen),
//   3 divisions (load, 39 bits, finish), 4 mac steps, then the result is presented
// a new window is taken only after the previous result has transferred;
//   a waiting result holds its register and the input stays not ready until its transfer
// reset (rst, synchronous) restores register defaults, clears seeded state and baselines, presets threshold
`timescale 1ns / 1ps
module ema_baseline_confidence_tracker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // level_rms[23:0], level_variance[47:24], hum_level[71:48], flatness[87:72],
  // trans_ratio[111:88]
  input  logic [111:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // level_confidence[15:0], hum_conf[31:16], flat_conf[47:32],
  // clarity[63:48], stability[79:64], base_rms[103:80],
  // base_variance[127:104], base_hum[151:128], base_texture[167:152],
  // threshold_now[191:168]
  output logic [191:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ebct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ebct_pkg::CFG_DATA_W-1:0] cfg_data
);
  logic [15:0] learn_rate;
  logic [23:0] threshold_start;
  logic [15:0] guard_epsilon;
  logic [16:0] w_level, w_hum, w_flat, w_clar;
  logic        freeze;

  ebct_pkg::state_t state;
  logic        seeded;
  logic [23:0] base [5];   // rms, var, hum, texture, threshold
  logic [23:0] feat [5];   // rms, var, hum, flat (saturated), transient
  logic [15:0] conf [4];
  logic [2:0]  idx;
  logic        phase;
  logic [40:0] acc;
  logic [38:0] dividend;   // shifted dividend register
  logic [24:0] divisor;
  logic [24:0] rem;
  logic [38:0] quo;
  logic [5:0]  step;
  logic        dzero;
  logic        dnz;
  logic [15:0] stab;

  assign cfg_ready = (state == ebct_pkg::ST_IDLE);
  assign s_axis_tready = (state == ebct_pkg::ST_IDLE) && !cfg_valid;
  assign m_axis_tvalid = (state == ebct_pkg::ST_OUT);

  // shared multiplier
  logic [24:0] mul_a;
  logic [16:0] mul_b;
  logic [41:0] prod;
  logic [16:0] alpha;
  assign alpha = (learn_rate == 16'd0) ? 17'd1 : {1'b0, learn_rate};
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ebct_pkg::ST_EMA) begin
      mul_a = {1'b0, phase ? base[idx] : feat[idx]};
      mul_b = phase ? (17'(ebct_pkg::ONE_Q16) - alpha) : alpha;
    end else begin
      mul_a = {9'd0, conf[idx[1:0]]};
      case (idx[1:0])
        2'd0: mul_b = w_level;
        2'd1: mul_b = w_hum;
        2'd2: mul_b = w_flat;
        default: mul_b = w_clar;
      endcase
    end
    prod = 42'(mul_a) * 42'(mul_b);
  end

  // divider trial subtraction
  logic [25:0] trial;
  assign trial = {rem, dividend[38]} - {1'b0, divisor};

  logic [23:0] dsel_x, dsel_b, absd;
  always_comb begin
    dsel_x = (idx == 3'd0) ? feat[0] : feat[2];
    dsel_b = (idx == 3'd0) ? base[0] : base[2];
    absd = (dsel_x > dsel_b) ? dsel_x - dsel_b : dsel_b - dsel_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= 16'd66;
      threshold_start <= 24'd196608;
      guard_epsilon <= 16'd1;
      w_level <= 17'd16384;
      w_hum <= 17'd16384;
      w_flat <= 17'd16384;
      w_clar <= 17'd16384;
      freeze <= 1'b0;
      state <= ebct_pkg::ST_IDLE;
      seeded <= 1'b0;
      for (int i = 0; i < 4; i++) base[i] <= '0;
      base[4] <= 24'd196608;
    end else begin
      case (state)
        ebct_pkg::ST_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index)
              ebct_pkg::REG_LEARN_RATE: learn_rate <= cfg_data[15:0];
              ebct_pkg::REG_THRESH_START: threshold_start <= cfg_data;
              ebct_pkg::REG_GUARD_EPS: guard_epsilon <= cfg_data[15:0];
              ebct_pkg::REG_W_LEVEL: w_level <= cfg_data[16:0];
              ebct_pkg::REG_W_HUM: w_hum <= cfg_data[16:0];
              ebct_pkg::REG_W_FLAT: w_flat <= cfg_data[16:0];
              ebct_pkg::REG_W_CLAR: w_clar <= cfg_data[16:0];
              ebct_pkg::REG_FREEZE: freeze <= cfg_data[0];
              default: ;
            endcase
          end else if (s_axis_tvalid) begin
            feat[0] <= s_axis_tdata[23:0];
            feat[1] <= s_axis_tdata[47:24];
            feat[2] <= s_axis_tdata[71:48];
            feat[3] <= (s_axis_tdata[87:72] > 16'(ebct_pkg::ONE_Q15)) ?
                       24'(ebct_pkg::ONE_Q15) : {8'd0, s_axis_tdata[87:72]};
            feat[4] <= s_axis_tdata[111:88];
            idx <= '0;
            phase <= 1'b0;
            acc <= 41'd32768;
            if (!seeded) begin
              seeded <= 1'b1;
              base[0] <= s_axis_tdata[23:0];
              base[1] <= s_axis_tdata[47:24];
              base[2] <= s_axis_tdata[71:48];
              base[3] <= (s_axis_tdata[87:72] > 16'(ebct_pkg::ONE_Q15)) ?
                         24'(ebct_pkg::ONE_Q15) : {8'd0, s_axis_tdata[87:72]};
              base[4] <= (threshold_start < 24'(ebct_pkg::ONE_Q16)) ?
                         24'(ebct_pkg::ONE_Q16) : threshold_start;
              state <= ebct_pkg::ST_DLD;
            end else if (freeze) begin
              state <= ebct_pkg::ST_DLD;
            end else begin
              state <= ebct_pkg::ST_EMA;
            end
          end
        end
        ebct_pkg::ST_EMA: begin
          if (!phase) begin
            acc <= acc + 41'(prod);
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            acc <= 41'd32768;
            if (idx == 3'd4) begin
              base[4] <= ((acc + 41'(prod)) < (41'(ebct_pkg::ONE_Q16) << 16)) ?
                         24'(ebct_pkg::ONE_Q16) : 24'((acc + 41'(prod)) >> 16);
              idx <= '0;
              state <= ebct_pkg::ST_DLD;
            end else begin
              base[idx] <= 24'((acc + 41'(prod)) >> 16);
              idx <= idx + 3'd1;
            end
          end
        end
        ebct_pkg::ST_DLD: begin
          // idx 0: level, 2: hum, 4: clarity
          rem <= '0;
          step <= '0;
          if (idx == 3'd4) begin
            dividend <= {feat[4], 15'd0};
            divisor <= 25'(base[4]) + 25'(guard_epsilon);
            dzero <= 1'b0;
            dnz <= 1'b0;
          end else begin
            dividend <= {absd, 15'd0};
            divisor <= 25'(dsel_b) + 25'(guard_epsilon);
            dzero <= (25'(dsel_b) + 25'(guard_epsilon)) == 25'd0;
            dnz <= absd != 24'd0;
          end
          quo <= '0;
          state <= ebct_pkg::ST_DIV;
        end
        ebct_pkg::ST_DIV: begin
          if (!trial[25]) rem <= trial[24:0];
          else rem <= {rem[23:0], dividend[38]};
          quo <= {quo[37:0], ~trial[25]};
          dividend <= {dividend[37:0], 1'b0};
          step <= step + 6'd1;
          if (step == 6'd38) state <= ebct_pkg::ST_FIN;
        end
        ebct_pkg::ST_FIN: begin
          if (idx == 3'd4) begin
            conf[3] <= (quo > 39'(ebct_pkg::ONE_Q15)) ? 16'(ebct_pkg::ONE_Q15) : quo[15:0];
            conf[2] <= feat[3][15:0];
            idx <= '0;
            acc <= 41'd32768;
            state <= ebct_pkg::ST_SUM;
          end else begin
            // idx 0 lands in slot 0, idx 2 in slot 1
            conf[idx[2:1]] <= dzero ? (dnz ? 16'd0 : 16'(ebct_pkg::ONE_Q15)) :
              ((quo > 39'(ebct_pkg::ONE_Q15)) ? 16'd0 : 16'(ebct_pkg::ONE_Q15) - quo[15:0]);
            idx <= idx + 3'd2;
            state <= ebct_pkg::ST_DLD;
          end
        end
        ebct_pkg::ST_SUM: begin
          acc <= acc + 41'(prod);
          if (idx == 3'd3) state <= ebct_pkg::ST_OUT;
          idx <= idx + 3'd1;
        end
        ebct_pkg::ST_OUT: begin
          if (m_axis_tready) state <= ebct_pkg::ST_IDLE;
        end
        default: state <= ebct_pkg::ST_IDLE;
      endcase
    end
  end

  assign stab = ((acc >> 16) > 41'(ebct_pkg::ONE_Q15)) ? 16'(ebct_pkg::ONE_Q15) : acc[31:16];
  assign m_axis_tdata = {base[4], base[3][15:0], base[2], base[1], base[0],
                         stab, conf[3], conf[2], conf[1], conf[0]};
endmodule
